>>> sv/tieu_pkg.sv
// ----------------------------------------------------------------------------
// tieu_pkg
// Opcodes, architectural constants and the result record of the execute unit.
// ----------------------------------------------------------------------------
package tieu_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_AND   = 4'd3,
    OP_OR    = 4'd4,
    OP_XOR   = 4'd5,
    OP_MOVC  = 4'd6,
    OP_LOAD  = 4'd7,
    OP_STORE = 4'd8,
    OP_BZ    = 4'd9,
    OP_BNZ   = 4'd10,
    OP_JUMP  = 4'd11,
    OP_HALT  = 4'd12
  } op_t;

  localparam logic [31:0] PC_RESET = 32'd4000;
  localparam logic [31:0] PC_STEP  = 32'd4;

  typedef struct packed {
    logic        reg_write;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        halted;
  } res_t;

endpackage

>>> sv/tieu_regfile.sv
// ----------------------------------------------------------------------------
// tieu_regfile
// Register file: synchronous memory, two read ports, one write port, per-entry
// valid bits for the all-zero reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
module tieu_regfile #(
  parameter int REG_COUNT = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(REG_COUNT)-1:0] rd_addr_a,
  input  logic [$clog2(REG_COUNT)-1:0] rd_addr_b,
  input  logic                         wr_en,
  input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
  input  logic [31:0]                  wr_data,
  output logic [31:0]                  rd_data_a,
  output logic [31:0]                  rd_data_b
);

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [31:0]          mem_a_r, mem_b_r, fwd_data_r;
  logic                 vld_a_r, vld_b_r, fwd_a_r, fwd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_a_r <= mem[rd_addr_a];
      mem_b_r <= mem[rd_addr_b];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a_r <= valid_r[rd_addr_a];
        vld_b_r <= valid_r[rd_addr_b];
        // a write landing on the same edge as the read wins
        fwd_a_r <= wr_en && (wr_addr == rd_addr_a);
        fwd_b_r <= wr_en && (wr_addr == rd_addr_b);
      end
    end
  end

  assign rd_data_a = fwd_a_r ? fwd_data_r : (vld_a_r ? mem_a_r : 32'd0);
  assign rd_data_b = fwd_b_r ? fwd_data_r : (vld_b_r ? mem_b_r : 32'd0);

endmodule

>>> sv/tieu_addr_wrap.sv
// ----------------------------------------------------------------------------
// tieu_addr_wrap
// Reduces a 32-bit byte-free word address modulo the data memory depth.
// Power-of-two depth: bit mask, combinational. Otherwise reciprocal multiply,
// back-multiply and one correction, two register stages.
// ----------------------------------------------------------------------------
module tieu_addr_wrap #(
  parameter int DATA_WORDS = 4096
) (
  input  logic                          clk,
  input  logic [31:0]                   addr_in,
  output logic [$clog2(DATA_WORDS)-1:0] idx
);

  localparam int AW      = $clog2(DATA_WORDS);
  localparam bit IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      assign idx = addr_in[AW-1:0];
    end else begin : g_recip
      localparam longint unsigned RECIP_L = (64'd1 << 32) / DATA_WORDS;
      localparam logic [31:0]     RECIP   = 32'(RECIP_L);
      localparam logic [31:0]     DEPTH   = 32'(DATA_WORDS);

      logic [63:0] prod;
      logic [63:0] back;
      logic [31:0] quo_r;
      logic [AW:0] addr_lo_r;
      logic [AW:0] rem_r;

      // quotient estimate is exact or one short, so the remainder is below 2*depth
      assign prod = 64'(addr_in) * 64'(RECIP);
      assign back = 64'(quo_r) * 64'(DEPTH);

      always_ff @(posedge clk) begin
        quo_r     <= prod[63:32];
        addr_lo_r <= addr_in[AW:0];
        rem_r     <= addr_lo_r - back[AW:0];
      end

      always_comb begin
        if (rem_r >= (AW+1)'(DATA_WORDS)) begin
          idx = AW'(rem_r - (AW+1)'(DATA_WORDS));
        end else begin
          idx = rem_r[AW-1:0];
        end
      end
    end
  endgenerate

endmodule

>>> sv/tieu_dmem.sv
// ----------------------------------------------------------------------------
// tieu_dmem
// Data memory: single-port synchronous RAM with registered read data and a
// zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module tieu_dmem #(
  parameter int DATA_WORDS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic                          wr_en,
  input  logic [$clog2(DATA_WORDS)-1:0] addr,
  input  logic [31:0]                   wr_data,
  output logic [31:0]                   rd_data,
  output logic                          clr_busy
);

  localparam int AW = $clog2(DATA_WORDS);

  logic [31:0]   mem [DATA_WORDS];
  logic [31:0]   rd_data_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign mem_we    = clr_busy_r || wr_en;
  assign mem_waddr = clr_busy_r ? clr_addr_r : addr;
  assign mem_wdata = clr_busy_r ? 32'd0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DATA_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

>>> sv/teaching_isa_execute_unit.sv
// ----------------------------------------------------------------------------
// teaching_isa_execute_unit
// Architectural execute stage of a small in-order teaching core.
// ----------------------------------------------------------------------------
// An instruction passes through a register file read and then a data memory
// access; when DATA_WORDS is not a power of two, the registered address
// reduction lies between the two, and no new instruction is taken before the
// previous one commits. The next instruction is taken on the edge where the
// previous one commits to the register file, pc and zero flag, so the
// register file read is forwarded from that write. The result sits in an
// output register, so one stalled result does not block the next
// instruction's read stage. After reset the data memory is zero-filled, and
// no instruction is taken until that sweep ends.
module teaching_isa_execute_unit #(
  parameter int DATA_WORDS = 4096,
  parameter int REG_COUNT  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // dest_reg[4:0], src1_reg[9:5], src2_reg[14:10],
                                  // immediate[30:15], zero[31]
  input  logic [3:0]  in_tuser,   // req_type[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // write_index[4:0], write_value[36:5],
                                  // branch_taken[37], next_pc[69:38], halted[70],
                                  // zero[71]
  output logic        out_tuser   // reg_write
);

  localparam int RW      = $clog2(REG_COUNT);
  localparam int AW      = $clog2(DATA_WORDS);
  localparam bit IS_POW2 = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
  localparam int LAT     = IS_POW2 ? 0 : 2;

  function automatic logic [RW-1:0] reg_wrap(input logic [4:0] v);
    logic [5:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 4; i++) begin
      if (t >= 6'(REG_COUNT)) begin
        t = t - 6'(REG_COUNT);
      end
    end
    return t[RW-1:0];
  endfunction

  // control
  logic        s1_v_r, s2_v_r, out_v_r;
  logic [1:0]  s1_cnt_r;
  logic        s1_last, s1_adv, commit, in_fire, out_fire;
  logic        clr_busy;

  // architectural state outside the memories
  logic [31:0] pc_r;
  logic        zf_r, halt_r;

  // stage 1 payload
  logic [3:0]    op_r;
  logic [RW-1:0] rd_r;
  logic [31:0]   imm_r;

  // stage 2 payload
  tieu_pkg::res_t s2_res_r, s2_res_nxt;
  logic           s2_load_r, s2_load_nxt;
  logic           s2_zf_upd_r, s2_zf_upd_nxt;
  logic           s2_zf_r, s2_zf_nxt;
  logic [RW-1:0]  s2_rd_r;

  tieu_pkg::res_t out_r, out_nxt;

  logic [31:0]   op_a, op_b, mem_base, mem_addr, load_data;
  logic [AW-1:0] mem_idx;
  logic          mem_rd, mem_wr;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_v_r && out_tready;
  assign commit   = s2_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_busy && !s1_v_r && (!s2_v_r || commit);
  assign s1_last  = s1_cnt_r == 2'(LAT);
  assign s1_adv   = s1_v_r && s1_last;

  tieu_regfile #(.REG_COUNT(REG_COUNT)) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_fire),
    .rd_addr_a (reg_wrap(in_tdata[9:5])),
    .rd_addr_b (reg_wrap(in_tdata[14:10])),
    .wr_en     (commit && s2_res_r.reg_write),
    .wr_addr   (s2_rd_r),
    .wr_data   (out_nxt.write_value),
    .rd_data_a (op_a),
    .rd_data_b (op_b)
  );

  assign mem_base = (op_r == tieu_pkg::OP_STORE) ? op_b : op_a;
  assign mem_addr = mem_base + imm_r;

  tieu_addr_wrap #(.DATA_WORDS(DATA_WORDS)) u_addr_wrap (
    .clk     (clk),
    .addr_in (mem_addr),
    .idx     (mem_idx)
  );

  assign mem_rd = s1_adv && !halt_r && (op_r == tieu_pkg::OP_LOAD);
  assign mem_wr = s1_adv && !halt_r && (op_r == tieu_pkg::OP_STORE);

  tieu_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd),
    .wr_en    (mem_wr),
    .addr     (mem_idx),
    .wr_data  (op_a),
    .rd_data  (load_data),
    .clr_busy (clr_busy)
  );

  // execute
  always_comb begin
    logic [31:0] val;
    logic        wr;
    val           = 32'd0;
    wr            = 1'b0;
    s2_load_nxt   = 1'b0;
    s2_zf_upd_nxt = 1'b0;
    s2_res_nxt.branch_taken = 1'b0;
    s2_res_nxt.next_pc      = pc_r + tieu_pkg::PC_STEP;
    s2_res_nxt.halted       = 1'b0;
    unique case (op_r)
      tieu_pkg::OP_ADD:  begin val = op_a + op_b; wr = 1'b1; s2_zf_upd_nxt = 1'b1; end
      tieu_pkg::OP_SUB:  begin val = op_a - op_b; wr = 1'b1; s2_zf_upd_nxt = 1'b1; end
      tieu_pkg::OP_MUL:  begin val = op_a * op_b; wr = 1'b1; s2_zf_upd_nxt = 1'b1; end
      tieu_pkg::OP_AND:  begin val = op_a & op_b; wr = 1'b1; end
      tieu_pkg::OP_OR:   begin val = op_a | op_b; wr = 1'b1; end
      tieu_pkg::OP_XOR:  begin val = op_a ^ op_b; wr = 1'b1; end
      tieu_pkg::OP_MOVC: begin val = imm_r; wr = 1'b1; end
      tieu_pkg::OP_LOAD: begin wr = 1'b1; s2_load_nxt = 1'b1; end
      tieu_pkg::OP_BZ: begin
        if (zf_r) begin
          s2_res_nxt.next_pc      = pc_r + imm_r;
          s2_res_nxt.branch_taken = 1'b1;
        end
      end
      tieu_pkg::OP_BNZ: begin
        if (!zf_r) begin
          s2_res_nxt.next_pc      = pc_r + imm_r;
          s2_res_nxt.branch_taken = 1'b1;
        end
      end
      tieu_pkg::OP_JUMP: begin
        s2_res_nxt.next_pc      = op_a + imm_r;
        s2_res_nxt.branch_taken = 1'b1;
      end
      tieu_pkg::OP_HALT: begin
        s2_res_nxt.next_pc = pc_r;
        s2_res_nxt.halted  = 1'b1;
      end
      default: ;   // store and unused codes: pc advance only
    endcase
    s2_zf_nxt              = val == 32'd0;
    s2_res_nxt.reg_write   = wr;
    s2_res_nxt.write_index = wr ? 5'(rd_r) : 5'd0;
    s2_res_nxt.write_value = val;
    // once halted, everything is a no-op
    if (halt_r) begin
      s2_res_nxt    = '0;
      s2_res_nxt.next_pc = pc_r;
      s2_res_nxt.halted  = 1'b1;
      s2_load_nxt   = 1'b0;
      s2_zf_upd_nxt = 1'b0;
    end
  end

  always_comb begin
    out_nxt = s2_res_r;
    if (s2_load_r) begin
      out_nxt.write_value = load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tuser;
      rd_r  <= reg_wrap(in_tdata[4:0]);
      imm_r <= {{16{in_tdata[30]}}, in_tdata[30:15]};
    end
    if (s1_adv) begin
      s2_res_r    <= s2_res_nxt;
      s2_load_r   <= s2_load_nxt;
      s2_zf_upd_r <= s2_zf_upd_nxt;
      s2_zf_r     <= s2_zf_nxt;
      s2_rd_r     <= rd_r;
    end
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_cnt_r <= 2'd0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pc_r     <= tieu_pkg::PC_RESET;
      zf_r     <= 1'b0;
      halt_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r   <= 1'b1;
        s1_cnt_r <= 2'd0;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end else if (s1_v_r) begin
        s1_cnt_r <= s1_cnt_r + 2'd1;
      end

      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (commit) begin
        s2_v_r <= 1'b0;
      end

      if (commit) begin
        out_v_r <= 1'b1;
        pc_r    <= s2_res_r.next_pc;
        halt_r  <= s2_res_r.halted;
        if (s2_zf_upd_r) begin
          zf_r <= s2_zf_r;
        end
      end else if (out_fire) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.reg_write;
  assign out_tdata  = {1'b0, out_r.halted, out_r.next_pc, out_r.branch_taken,
                       out_r.write_value, out_r.write_index};

  // one instruction in flight between read and commit
  a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_v_r && s2_v_r))
    else $error("two instructions in flight");

  a_no_exec_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !clr_busy)
    else $error("instruction executing during memory clear");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r && $stable(pc_r))
    else $error("halt state left or pc moved after halt");

  a_halted_noop: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && halt_r) |=> out_r.halted && !out_r.reg_write && !out_r.branch_taken)
    else $error("halted core produced an effect");

  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> out_v_r && $stable(out_r))
    else $error("output overwritten while stalled");

endmodule
